@@ hdl/hhs_pkg.sv @@
// hhs_pkg: types, codes and reset constants for the heater handle supervisor
// used by hhs_cfg_regs, hhs_step and heater_handle_supervisor; no dependencies

package hhs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLEEP_TICKS       = 3'd0,
    CFG_ERROR_TICKS       = 3'd1,
    CFG_MAX_TEMP          = 3'd2,
    CFG_MIN_TEMP          = 3'd3,
    CFG_MIN_AIR           = 3'd4,
    CFG_POWER_TEMP_OFFSET = 3'd5,
    CFG_MAX_AIR           = 3'd6,
    CFG_SLEEP_FAN_LEVEL   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FAULT_OK       = 2'd0,
    FAULT_OVER_TMP = 2'd1,
    FAULT_LOW_TMP  = 2'd2,
    FAULT_FAN      = 2'd3
  } fault_e;

  localparam logic [1:0] ModeCold  = 2'd1;
  localparam logic [1:0] ModePower = 2'd2;

  localparam logic [9:0] TempFanHigh   = 10'd250;
  localparam logic [9:0] TempFanLow    = 10'd70;
  localparam logic [9:0] TempSleepCool = 10'd70;
  localparam logic [9:0] TempFanOff    = 10'd40;
  localparam logic [7:0] SleepDuty     = 8'd50;

  localparam logic [15:0] RstSleepTicks     = 16'd100;
  localparam logic [14:0] RstErrorTicks     = 15'd5;
  localparam logic [9:0]  RstMaxTemp        = 10'd520;
  localparam logic [9:0]  RstMinTemp        = 10'd10;
  localparam logic [7:0]  RstMinAir         = 8'd10;
  localparam logic [7:0]  RstPowerOffset    = 8'd50;
  localparam logic [7:0]  RstMaxAir         = 8'd100;
  localparam logic [7:0]  RstSleepFanLevel  = 8'd50;

  typedef struct packed {
    logic       handle_lifted;
    logic       sleep_enabled;
    logic [1:0] tool_mode;
    logic [9:0] heater_temp;
    logic [7:0] air_flow;
    logic [7:0] air_setting;
    logic [7:0] cold_air_setting;
  } in_t;

  typedef struct packed {
    logic       working;
    logic [1:0] fault_code;
    logic [7:0] fan_duty;
    logic       sleep_beep;
  } out_t;

  typedef struct packed {
    logic [15:0] sleep_ticks;
    logic [14:0] error_ticks;
    logic [9:0]  max_temp;
    logic [9:0]  min_temp;
    logic [7:0]  min_air;
    logic [7:0]  power_temp_offset;
    logic [7:0]  max_air;
    logic [7:0]  sleep_fan_level;
  } cfg_t;

  typedef struct packed {
    logic        work;
    logic [15:0] sleep_cnt;
    logic [15:0] fault_cnt;
    logic        fault_latched;
    fault_e      fault_state;
    logic        fan_fault;
    logic        fan_hold;
    logic [7:0]  duty;
  } state_t;

  // floor(level*56/100)+30 = floor(level*14/25)+30, /25 by reciprocal 2622/2^16
  function automatic logic [7:0] scaled_air(input logic [7:0] level);
    logic [11:0] n;
    logic [23:0] p;
    n = 12'(level) * 12'd14;
    p = 24'(n) * 24'd2622;
    return 8'(p[23:16]) + 8'd30;
  endfunction

  // floor(temp*4/10) = floor(temp*2/5), /5 by reciprocal 1639/2^13
  function automatic logic [7:0] temp_duty(input logic [9:0] temp);
    logic [10:0] n;
    logic [21:0] p;
    n = {temp, 1'b0};
    p = 22'(n) * 22'd1639;
    return p[20:13];
  endfunction

endpackage

@@ hdl/hhs_cfg_regs.sv @@
// hhs_cfg_regs: configuration register file with reset values
// depends on hhs_pkg

module hhs_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [hhs_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [hhs_pkg::CfgDataW-1:0] data_i,
  output hhs_pkg::cfg_t                cfg_o
);
  import hhs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_SLEEP_TICKS:       cfg_d.sleep_ticks       = data_i;
        CFG_ERROR_TICKS:       cfg_d.error_ticks       = data_i[14:0];
        CFG_MAX_TEMP:          cfg_d.max_temp          = data_i[9:0];
        CFG_MIN_TEMP:          cfg_d.min_temp          = data_i[9:0];
        CFG_MIN_AIR:           cfg_d.min_air           = data_i[7:0];
        CFG_POWER_TEMP_OFFSET: cfg_d.power_temp_offset = data_i[7:0];
        CFG_MAX_AIR:           cfg_d.max_air           = data_i[7:0];
        CFG_SLEEP_FAN_LEVEL:   cfg_d.sleep_fan_level   = data_i[7:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_ticks       <= RstSleepTicks;
      cfg_q.error_ticks       <= RstErrorTicks;
      cfg_q.max_temp          <= RstMaxTemp;
      cfg_q.min_temp          <= RstMinTemp;
      cfg_q.min_air           <= RstMinAir;
      cfg_q.power_temp_offset <= RstPowerOffset;
      cfg_q.max_air           <= RstMaxAir;
      cfg_q.sleep_fan_level   <= RstSleepFanLevel;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/hhs_step.sv @@
// hhs_step: one control tick of sleep state, fault detector and fan duty
// combinational; depends on hhs_pkg

module hhs_step (
  input  hhs_pkg::state_t state_i,
  input  hhs_pkg::cfg_t   cfg_i,
  input  hhs_pkg::in_t    item_i,
  output hhs_pkg::state_t state_o,
  output hhs_pkg::out_t   res_o
);
  import hhs_pkg::*;

  logic        cold;
  logic        power;
  logic        docked;
  logic        beep;
  logic [10:0] cool_lim;
  logic [15:0] sleep_inc;
  logic [15:0] fault_inc;
  logic        air_low;
  logic        hot;
  logic        cool;
  logic [15:0] err_half;
  logic [15:0] err_dbl;
  state_t      n;

  always_comb begin
    cold      = (item_i.tool_mode == ModeCold);
    power     = (item_i.tool_mode == ModePower);
    docked    = !item_i.handle_lifted && item_i.sleep_enabled;
    beep      = 1'b0;
    cool_lim  = power ? 11'(TempSleepCool) + 11'(cfg_i.power_temp_offset)
                      : 11'(TempSleepCool);
    sleep_inc = state_i.sleep_cnt + 16'd1;
    air_low   = item_i.air_flow < cfg_i.min_air;
    hot       = item_i.heater_temp >= cfg_i.max_temp;
    cool      = item_i.heater_temp <= cfg_i.min_temp;
    err_half  = 16'(cfg_i.error_ticks[14:1]);
    err_dbl   = {cfg_i.error_ticks, 1'b0};
    n         = state_i;

    // sleep / working
    if (!state_i.work) begin
      if (!docked || cold) begin
        n.work = 1'b1;
      end
      n.fault_cnt = '0;
    end else if (docked && !cold) begin
      if (11'(item_i.heater_temp) <= cool_lim) begin
        n.sleep_cnt = sleep_inc;
        if (sleep_inc > cfg_i.sleep_ticks) begin
          n.work      = 1'b0;
          n.sleep_cnt = '0;
          beep        = 1'b1;
        end
      end
    end

    // fault detector
    fault_inc = n.fault_cnt + 16'd1;
    if (!state_i.fault_latched) begin
      if (cold) begin
        if (air_low) begin
          n.fault_cnt = fault_inc;
          if (fault_inc > err_dbl) begin
            n.fault_state   = FAULT_FAN;
            n.fault_cnt     = '0;
            n.fault_latched = 1'b1;
          end
        end
      end else if (!docked) begin
        if (hot || cool || air_low) begin
          n.fault_cnt = fault_inc;
          if (fault_inc > err_half && hot) begin
            n.fault_state   = FAULT_OVER_TMP;
            n.fault_cnt     = '0;
            n.fault_latched = 1'b1;
          end else if (fault_inc > err_dbl) begin
            if (air_low) begin
              n.fault_state   = FAULT_FAN;
              n.fault_cnt     = '0;
              n.fault_latched = 1'b1;
            end else if (cool) begin
              n.fault_state   = FAULT_LOW_TMP;
              n.fault_cnt     = '0;
              n.fault_latched = 1'b1;
            end
          end
        end else begin
          n.fault_cnt = '0;
        end
      end else begin
        n.fault_cnt = '0;
      end
    end else if (docked) begin
      n.fault_state   = FAULT_OK;
      n.fault_cnt     = '0;
      n.fault_latched = 1'b0;
    end

    // fan duty
    if (!state_i.fan_fault) begin
      if (n.fault_state != FAULT_OK) begin
        n.fan_fault = 1'b1;
      end else if (cold) begin
        n.fan_hold = 1'b1;
        n.duty     = scaled_air(item_i.cold_air_setting);
      end else if (!n.work) begin
        if (item_i.heater_temp >= TempFanOff) begin
          if (!state_i.fan_hold) n.duty = SleepDuty;
        end else if (!state_i.fan_hold) begin
          n.fan_hold = 1'b1;
          n.duty     = '0;
        end
      end else if (docked) begin
        n.fan_hold = 1'b0;
        if (item_i.heater_temp >= TempFanHigh) begin
          n.duty = scaled_air(cfg_i.sleep_fan_level);
        end else if (item_i.heater_temp >= TempFanLow) begin
          n.duty = temp_duty(item_i.heater_temp);
        end else begin
          n.duty = '0;
        end
      end else begin
        n.fan_hold = 1'b1;
        n.duty     = scaled_air(item_i.air_setting);
      end
    end else begin
      n.duty = scaled_air(cfg_i.max_air);
      if (n.fault_state == FAULT_OK) n.fan_fault = 1'b0;
    end

    state_o          = n;
    res_o.working    = n.work;
    res_o.fault_code = n.fault_state;
    res_o.fan_duty   = n.duty;
    res_o.sleep_beep = beep;
  end

endmodule

@@ hdl/heater_handle_supervisor.sv @@
// heater_handle_supervisor: top level with input register, state and result register
// depends on hhs_pkg, hhs_cfg_regs and hhs_step
//
// usage:
//   in channel: one beat per control tick carries the handle position, modes,
//   temperature, airflow and air settings; out channel: one result beat per
//   input beat, in order (working, fault code, fan duty, long beep)
//   cfg channel: register index and data, always ready; write only while idle
// latency: 2 cycles from input beat to result valid (input register, then the
//   tick logic into the result register)
// throughput: 1 beat per cycle; the tick logic reads and updates the state
//   registers in a single cycle, so consecutive beats follow each other
// reset: all state cleared (sleep, no fault, duty 0), registers take their
//   reset values, both stages empty
// stall: when the receiver holds out_ready_i low, the result stays in the
//   output register and one more beat waits in the input register; in_ready_o
//   drops only when both are full

module heater_handle_supervisor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hhs_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hhs_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hhs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hhs_pkg::CfgDataW-1:0] cfg_data_i
);
  import hhs_pkg::*;

  cfg_t   cfg;
  in_t    in_q;
  logic   in_valid_q;
  state_t state_q, state_d;
  out_t   out_q, out_d;
  logic   out_valid_q;
  logic   advance;

  assign cfg_ready_o = 1'b1;

  hhs_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  hhs_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg),
    .item_i  (in_q),
    .state_o (state_d),
    .res_o   (out_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_latch_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fault_latched == (state_q.fault_state != FAULT_OK))
    else $error("fault latch and fault code disagree");

  a_beep_means_sleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sleep_beep |-> !out_data_o.working)
    else $error("long beep without sleep entry");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q) && $stable(state_q))
    else $error("stalled result or state changed");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted with both stages full");
`endif

endmodule

@@ tb/heater_handle_supervisor_test.sv @@
// heater_handle_supervisor_test: self-checking testbench for the heater handle supervisor
// drives random-gap tick beats and register writes, predicts every result beat in-line
// depends on hhs_pkg and heater_handle_supervisor

module heater_handle_supervisor_test;
  import hhs_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PhaseTicks = 212;

  typedef enum int {
    EP_CRADLE_COOL,
    EP_CRADLE_HOT,
    EP_LIFTED_WORK,
    EP_OVER_TEMP,
    EP_LOW_TEMP,
    EP_FAN_FAULT,
    EP_COLD_AIR,
    EP_NOISE
  } episode_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready_o;
  in_t                 in_data = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  heater_handle_supervisor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // register copy and supervisor state as the predictor sees them
  cfg_t        sup_cfg = '{
    sleep_ticks: RstSleepTicks, error_ticks: RstErrorTicks, max_temp: RstMaxTemp,
    min_temp: RstMinTemp, min_air: RstMinAir, power_temp_offset: RstPowerOffset,
    max_air: RstMaxAir, sleep_fan_level: RstSleepFanLevel
  };
  logic        sup_working = 1'b0;
  logic [15:0] sup_sleep_cnt = '0;
  logic [15:0] sup_fault_cnt = '0;
  logic        sup_latched = 1'b0;
  fault_e      sup_fault = FAULT_OK;
  logic        sup_fan_fault = 1'b0;
  logic        sup_fan_hold = 1'b0;
  logic [7:0]  sup_duty = '0;

  in_t  pending_ticks[$];
  bit   pending_drain[$];
  out_t expected_results[$];

  int   cycle_count = 0;
  int   error_count = 0;
  int   sent_count = 0;
  int   result_count = 0;
  int   sleep_entries = 0;
  int   fault_latches = 0;
  int   settings_count = 0;
  int   queued_count = 0;

  int   send_gap = 0;
  bit   send_calm = 1'b0;
  int   recv_gap = 0;
  bit   recv_calm = 1'b0;
  logic next_valid;
  in_t  next_data;
  out_t want_result;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] air_duty(input logic [7:0] level);
    int unsigned x;
    x = (int'(level) * 56) / 100 + 30;
    return x[7:0];
  endfunction

  function automatic out_t tick_supervisor(input in_t t);
    out_t r;
    logic cold, beep, air_low, hot, cool_t;
    int   act;
    int unsigned tduty;
    cold = (t.tool_mode == ModeCold);
    beep = 1'b0;

    if (!sup_working) begin
      if (!t.sleep_enabled || t.handle_lifted || cold) sup_working = 1'b1;
      sup_fault_cnt = '0;
    end else if (!t.handle_lifted && t.sleep_enabled && !cold) begin
      act = int'(t.heater_temp);
      if (t.tool_mode == ModePower) act = act - int'(sup_cfg.power_temp_offset);
      if (act <= int'(TempSleepCool)) begin
        sup_sleep_cnt = sup_sleep_cnt + 16'd1;
        if (sup_sleep_cnt > sup_cfg.sleep_ticks) begin
          sup_working = 1'b0;
          sup_sleep_cnt = '0;
          beep = 1'b1;
          sleep_entries++;
        end
      end
    end

    if (!sup_latched) begin
      air_low = t.air_flow < sup_cfg.min_air;
      if (cold) begin
        if (air_low) begin
          sup_fault_cnt = sup_fault_cnt + 16'd1;
          if (sup_fault_cnt > {sup_cfg.error_ticks, 1'b0}) begin
            sup_fault = FAULT_FAN; sup_fault_cnt = '0; sup_latched = 1'b1;
          end
        end
      end else if (t.handle_lifted || !t.sleep_enabled) begin
        hot = t.heater_temp >= sup_cfg.max_temp;
        cool_t = t.heater_temp <= sup_cfg.min_temp;
        if (hot || cool_t || air_low) begin
          sup_fault_cnt = sup_fault_cnt + 16'd1;
          if (sup_fault_cnt > 16'(sup_cfg.error_ticks >> 1) && hot) begin
            sup_fault = FAULT_OVER_TMP; sup_fault_cnt = '0; sup_latched = 1'b1;
          end else if (sup_fault_cnt > {sup_cfg.error_ticks, 1'b0}) begin
            if (air_low) begin
              sup_fault = FAULT_FAN; sup_fault_cnt = '0; sup_latched = 1'b1;
            end else if (cool_t) begin
              sup_fault = FAULT_LOW_TMP; sup_fault_cnt = '0; sup_latched = 1'b1;
            end
          end
        end else begin
          sup_fault_cnt = '0;
        end
      end else begin
        sup_fault_cnt = '0;
      end
      if (sup_latched) fault_latches++;
    end else if (!t.handle_lifted && t.sleep_enabled) begin
      sup_fault = FAULT_OK; sup_fault_cnt = '0; sup_latched = 1'b0;
    end

    if (!sup_fan_fault) begin
      if (sup_fault != FAULT_OK) begin
        sup_fan_fault = 1'b1;
      end else if (cold) begin
        sup_fan_hold = 1'b1;
        sup_duty = air_duty(t.cold_air_setting);
      end else if (!sup_working) begin
        if (t.heater_temp >= TempFanOff) begin
          if (!sup_fan_hold) sup_duty = SleepDuty;
        end else if (!sup_fan_hold) begin
          sup_fan_hold = 1'b1;
          sup_duty = '0;
        end
      end else if (!t.handle_lifted && t.sleep_enabled) begin
        sup_fan_hold = 1'b0;
        if (t.heater_temp >= TempFanHigh) begin
          sup_duty = air_duty(sup_cfg.sleep_fan_level);
        end else if (t.heater_temp >= TempFanLow) begin
          tduty = (int'(t.heater_temp) * 4) / 10;
          sup_duty = tduty[7:0];
        end else begin
          sup_duty = '0;
        end
      end else begin
        sup_fan_hold = 1'b1;
        sup_duty = air_duty(t.air_setting);
      end
    end else begin
      sup_duty = air_duty(sup_cfg.max_air);
      if (sup_fault == FAULT_OK) sup_fan_fault = 1'b0;
    end

    r.working = sup_working;
    r.fault_code = sup_fault;
    r.fan_duty = sup_duty;
    r.sleep_beep = beep;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(3, 1);
    if (p < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", result_count, what, got,
             want);
    error_count++;
  endtask

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid;
      next_data = in_data;
      if (in_valid && in_ready_o) begin
        expected_results.push_back(tick_supervisor(in_data));
        sent_count++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ticks.size() > 0 &&
                     !(pending_drain[0] && expected_results.size() != 0)) begin
          next_data = pending_ticks.pop_front();
          void'(pending_drain.pop_front());
          next_valid = 1'b1;
          send_gap = send_calm ? 0 : pick_gap();
          if ($urandom_range(149) == 0) send_calm = !send_calm;
        end
      end
      in_valid <= next_valid;
      in_data <= next_data;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("beat without expectation", 1, 0);
        end else begin
          want_result = expected_results.pop_front();
          if (out_data_o.working !== want_result.working)
            report_mismatch("working", out_data_o.working, want_result.working);
          if (out_data_o.fault_code !== want_result.fault_code)
            report_mismatch("fault_code", out_data_o.fault_code, want_result.fault_code);
          if (out_data_o.fan_duty !== want_result.fan_duty)
            report_mismatch("fan_duty", out_data_o.fan_duty, want_result.fan_duty);
          if (out_data_o.sleep_beep !== want_result.sleep_beep)
            report_mismatch("sleep_beep", out_data_o.sleep_beep, want_result.sleep_beep);
        end
        recv_gap = recv_calm ? 0 : pick_gap();
        if ($urandom_range(149) == 0) recv_calm = !recv_calm;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_tick(input in_t t, input bit drain);
    pending_ticks.push_back(t);
    pending_drain.push_back(drain);
    queued_count++;
  endtask

  task automatic push_fields(input logic lifted, input logic sleep_on, input logic [1:0] mode,
                             input int temp, input int air, input int air_set,
                             input int cold_set);
    in_t t;
    t.handle_lifted = lifted;
    t.sleep_enabled = sleep_on;
    t.tool_mode = mode;
    t.heater_temp = 10'(temp);
    t.air_flow = 8'(air);
    t.air_setting = 8'(air_set);
    t.cold_air_setting = 8'(cold_set);
    push_tick(t, 1'b0);
  endtask

  function automatic logic [1:0] warm_mode();
    logic [1:0] m;
    m = 2'($urandom_range(2));
    if (m == ModeCold) m = 2'd3;
    return m;
  endfunction

  task automatic off_cradle(inout in_t t);
    if ($urandom_range(1)) t.handle_lifted = 1'b1;
    else t.sleep_enabled = 1'b0;
  endtask

  task automatic add_episode(input episode_e kind, input bit drain_first);
    in_t t;
    int  len, lo, hi, i;
    case (kind)
      EP_CRADLE_COOL: begin
        len = (sup_cfg.sleep_ticks > 30 ? 30 : int'(sup_cfg.sleep_ticks)) +
              $urandom_range(4, 1);
      end
      EP_OVER_TEMP, EP_LOW_TEMP, EP_FAN_FAULT: begin
        len = 2 * int'(sup_cfg.error_ticks) + $urandom_range(3, 1);
        if (len > 30) len = $urandom_range(30, 10);
      end
      default: len = $urandom_range(12, 1);
    endcase
    for (i = 0; i < len; i++) begin
      t.handle_lifted = 1'($urandom);
      t.sleep_enabled = 1'($urandom);
      t.tool_mode = 2'($urandom);
      t.heater_temp = 10'($urandom);
      t.air_flow = 8'($urandom);
      t.air_setting = 8'($urandom);
      t.cold_air_setting = 8'($urandom);
      case (kind)
        EP_CRADLE_COOL: begin
          t.handle_lifted = 1'b0;
          t.sleep_enabled = 1'b1;
          t.tool_mode = warm_mode();
          if ($urandom_range(9) != 0) begin
            hi = int'(TempSleepCool);
            if (t.tool_mode == ModePower) hi = hi + int'(sup_cfg.power_temp_offset);
            if (hi > 1023) hi = 1023;
            t.heater_temp = 10'($urandom_range(hi));
          end
        end
        EP_CRADLE_HOT: begin
          t.handle_lifted = 1'b0;
          t.sleep_enabled = 1'b1;
          t.tool_mode = warm_mode();
          t.heater_temp = 10'($urandom_range(1023, 71));
        end
        EP_LIFTED_WORK: begin
          off_cradle(t);
          t.tool_mode = warm_mode();
          lo = int'(sup_cfg.min_temp) + 1;
          hi = int'(sup_cfg.max_temp) - 1;
          if (lo <= hi) t.heater_temp = 10'($urandom_range(hi, lo));
          if (t.air_flow < sup_cfg.min_air)
            t.air_flow = 8'($urandom_range(255, sup_cfg.min_air));
        end
        EP_OVER_TEMP: begin
          off_cradle(t);
          t.tool_mode = warm_mode();
          t.heater_temp = 10'($urandom_range(1023, sup_cfg.max_temp));
        end
        EP_LOW_TEMP: begin
          off_cradle(t);
          t.tool_mode = warm_mode();
          t.heater_temp = 10'($urandom_range(sup_cfg.min_temp));
          if ($urandom_range(3) != 0 && t.air_flow < sup_cfg.min_air)
            t.air_flow = 8'($urandom_range(255, sup_cfg.min_air));
        end
        EP_FAN_FAULT: begin
          if (sup_cfg.min_air != 0) t.air_flow = 8'($urandom_range(sup_cfg.min_air - 1));
          if ($urandom_range(3) != 0) off_cradle(t);
        end
        EP_COLD_AIR: t.tool_mode = ModeCold;
        default: ;
      endcase
      push_tick(t, drain_first && i == 0);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SLEEP_TICKS:       sup_cfg.sleep_ticks = value;
      CFG_ERROR_TICKS:       sup_cfg.error_ticks = value[14:0];
      CFG_MAX_TEMP:          sup_cfg.max_temp = value[9:0];
      CFG_MIN_TEMP:          sup_cfg.min_temp = value[9:0];
      CFG_MIN_AIR:           sup_cfg.min_air = value[7:0];
      CFG_POWER_TEMP_OFFSET: sup_cfg.power_temp_offset = value[7:0];
      CFG_MAX_AIR:           sup_cfg.max_air = value[7:0];
      CFG_SLEEP_FAN_LEVEL:   sup_cfg.sleep_fan_level = value[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // every queued beat accepted and every result beat taken
  task automatic wait_idle();
    do @(posedge clk_i);
    while (sent_count != queued_count || result_count != sent_count);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    cfg_t     pc;
    int       p, target, mid, k;
    bit       drained;
    episode_e kind;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks under reset settings
    push_fields(1'b0, 1'b1, 2'd0, 0, 255, 0, 0);
    push_fields(1'b0, 1'b1, 2'd0, 1023, 0, 255, 255);
    push_fields(1'b1, 1'b1, 2'd0, 300, 100, 255, 0);
    push_fields(1'b1, 1'b1, 2'd0, 300, 100, 0, 0);
    push_fields(1'b0, 1'b1, 2'd3, 100, 100, 10, 10);
    push_fields(1'b0, 1'b1, ModePower, 10, 100, 10, 10);
    push_fields(1'b0, 1'b1, ModePower, 120, 100, 10, 10);
    push_fields(1'b0, 1'b1, ModeCold, 500, 255, 0, 255);
    push_fields(1'b0, 1'b0, ModeCold, 500, 0, 0, 0);
    push_fields(1'b0, 1'b1, 2'd0, 250, 100, 0, 0);
    push_fields(1'b0, 1'b1, 2'd0, 249, 100, 0, 0);
    push_fields(1'b0, 1'b1, 2'd0, 70, 100, 0, 0);
    push_fields(1'b0, 1'b1, 2'd0, 69, 100, 0, 0);
    for (k = 0; k < 5; k++) push_fields(1'b0, 1'b0, 2'd0, 1023, 255, 128, 128);
    push_fields(1'b1, 1'b0, 2'd3, 600, 255, 128, 128);
    push_fields(1'b0, 1'b1, 2'd0, 600, 255, 128, 128);
    push_fields(1'b0, 1'b1, 2'd0, 600, 255, 128, 128);
    push_fields(1'b1, 1'b0, 2'd0, 0, 0, 255, 255);
    wait_idle();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: pc = '0;
        1: pc = '{
             sleep_ticks: 16'd65534, error_ticks: 15'd32767, max_temp: 10'd1023,
             min_temp: 10'd1023, min_air: 8'd255, power_temp_offset: 8'd255,
             max_air: 8'd255, sleep_fan_level: 8'd255
           };
        default: begin
          pc.sleep_ticks = ($urandom_range(7) == 0) ? 16'($urandom_range(300))
                                                    : 16'($urandom_range(20));
          pc.error_ticks = 15'($urandom_range(8));
          pc.max_temp = 10'($urandom_range(600, 300));
          pc.min_temp = 10'($urandom_range(60));
          pc.min_air = 8'($urandom_range(60, 5));
          pc.power_temp_offset = 8'($urandom);
          pc.max_air = 8'($urandom);
          pc.sleep_fan_level = 8'($urandom);
        end
      endcase
      write_reg(CFG_SLEEP_TICKS, pc.sleep_ticks);
      write_reg(CFG_ERROR_TICKS, 16'(pc.error_ticks));
      write_reg(CFG_MAX_TEMP, 16'(pc.max_temp));
      write_reg(CFG_MIN_TEMP, 16'(pc.min_temp));
      write_reg(CFG_MIN_AIR, 16'(pc.min_air));
      write_reg(CFG_POWER_TEMP_OFFSET, 16'(pc.power_temp_offset));
      write_reg(CFG_MAX_AIR, 16'(pc.max_air));
      write_reg(CFG_SLEEP_FAN_LEVEL, 16'(pc.sleep_fan_level));
      settings_count++;

      target = queued_count + PhaseTicks;
      mid = queued_count + PhaseTicks / 2;
      drained = 1'b0;
      while (queued_count < target) begin
        k = $urandom_range(99);
        if (k < 25) kind = EP_CRADLE_COOL;
        else if (k < 35) kind = EP_CRADLE_HOT;
        else if (k < 50) kind = EP_LIFTED_WORK;
        else if (k < 60) kind = EP_OVER_TEMP;
        else if (k < 70) kind = EP_LOW_TEMP;
        else if (k < 80) kind = EP_FAN_FAULT;
        else if (k < 90) kind = EP_COLD_AIR;
        else kind = EP_NOISE;
        add_episode(kind, !drained && queued_count >= mid);
        if (queued_count > mid) drained = 1'b1;
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    $display("covered %0d tick beats and %0d result beats over %0d register settings",
             sent_count, result_count, settings_count);
    $display("sleep entered %0d times, faults latched %0d times, %0d mismatches",
             sleep_entries, fault_latches, error_count);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
